// ----- src/fpsub_pkg.sv -----
// Package for the binary64 same-sign subtract unit.
// Holds widths, field constants and the stage-to-stage payload types; no dependencies.
package fpsub_pkg;

	localparam int unsigned WordW  = 64;
	localparam int unsigned ExpW   = 11;
	localparam int unsigned FracW  = 52;
	localparam int unsigned GuardW = 6;
	// Working mantissa: hidden bit, fraction, guard bits, plus one carry bit.
	localparam int unsigned ManW   = FracW + GuardW + 2;
	localparam int unsigned ShW    = 6;
	localparam logic [ExpW-1:0] ExpMax = '1;
	localparam logic [ManW-1:0] RoundAdd = ManW'(32);
	localparam logic [ExpW-1:0] DropLimit = ExpW'(53);
	localparam logic [WordW-1:0] DefaultNanReset = 64'h7FF8_0000_0000_0000;

	// Unpack stage result: either a finished word or operands ready to subtract.
	typedef struct packed {
		logic             done;
		logic [WordW-1:0] word;
		logic             sign;
		logic [ExpW-1:0]  e1;
		logic [ManW-1:0]  m1;
		logic [ManW-1:0]  m2;
	} align_t;

	// Difference stage result.
	typedef struct packed {
		logic             done;
		logic [WordW-1:0] word;
		logic             sign;
		logic [ExpW-1:0]  e1;
		logic [ManW-1:0]  diff;
	} diff_t;

	// Normalize stage result.
	typedef struct packed {
		logic             done;
		logic [WordW-1:0] word;
		logic             sign;
		logic [ExpW-1:0]  e1;
		logic [ManW-1:0]  man;
	} norm_t;

endpackage

// ----- src/fpsub_if.sv -----
// Valid/ready channel interface carrying two operand words and a result word.
// Depends on fpsub_pkg for the default width.
interface fpsub_if #(
	parameter int unsigned W = fpsub_pkg::WordW
) (
	input logic clk
);
	logic         valid;
	logic         ready;
	logic [W-1:0] a_bits;
	logic [W-1:0] b_bits;
	logic [W-1:0] result_bits;

	modport source (output valid, output a_bits, output b_bits, output result_bits,
		input ready);
	modport sink (input valid, input a_bits, input b_bits, input result_bits,
		output ready);
endinterface

// ----- src/fp64_same_sign_subtract.sv -----
// Binary64 same-sign subtract unit: top level with a four-stage pipeline.
// Depends on fpsub_pkg, fpsub_if, fpsub_unpack and fpsub_norm.

// Computes a minus b for binary64 operands assumed to share a sign, one request
// per clock while the output is not stalled. Stage 1 compares magnitudes, handles
// NaN, infinity and denormal pairs, and aligns the smaller mantissa; stage 2
// subtracts; stage 3 normalizes; stage 4 rounds half-up without sticky and
// packs the word. Valid bits travel with each stage and the whole pipeline
// holds while the output request is not taken, so nothing is lost or repeated.
// default_nan is written by cfg_we/cfg_data and returned for inf minus inf.
module fp64_same_sign_subtract #(
	parameter logic [63:0] DefaultNan = fpsub_pkg::DefaultNanReset
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [63:0]  cfg_data,
	fpsub_if.sink        in_ch,
	fpsub_if.source      out_ch
);
	localparam int unsigned MW = fpsub_pkg::ManW;
	localparam int unsigned EW = fpsub_pkg::ExpW;
	localparam int unsigned GW = fpsub_pkg::GuardW;

	logic [63:0]        default_nan_q;
	logic               v_s1, v_s2, v_s3, v_s4;
	fpsub_pkg::align_t  al, al_s1;
	fpsub_pkg::diff_t   df, df_s2;
	fpsub_pkg::norm_t   nm, nm_s3;
	logic [63:0]        out_s4;
	logic               adv;
	logic [MW-1:0]      rnd;
	logic [EW-1:0]      re;
	logic [63:0]        packed_w;

	// Advance everything when the output slot is free or being taken.
	assign adv = !v_s4 || out_ch.ready;
	assign in_ch.ready = adv;
	assign out_ch.valid = v_s4;
	assign out_ch.result_bits = out_s4;
	assign out_ch.a_bits = '0;
	assign out_ch.b_bits = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			default_nan_q <= DefaultNan;
		else if (cfg_we)
			default_nan_q <= cfg_data;
	end

	fpsub_unpack u_unpack (
		.a(in_ch.a_bits), .b(in_ch.b_bits), .default_nan(default_nan_q), .res(al)
	);

	always_comb begin
		df.done = al_s1.done;
		df.word = al_s1.word;
		df.sign = al_s1.sign;
		df.e1 = al_s1.e1;
		df.diff = al_s1.m1 - al_s1.m2;
		if (!al_s1.done && df.diff == '0) begin
			df.done = 1'b1;
			df.word = '0;
		end
	end

	fpsub_norm u_norm (.d(df_s2), .n(nm));

	always_comb begin
		// Round half-up, renormalize on carry, encode denormal if hidden bit clear.
		rnd = nm_s3.man + fpsub_pkg::RoundAdd;
		re = nm_s3.e1;
		if (rnd[MW-1]) begin
			re = re + EW'(1);
			rnd = rnd >> 1;
		end
		packed_w = {nm_s3.sign, rnd[MW-2] ? re : {EW{1'b0}},
			rnd[GW +: fpsub_pkg::FracW]};
		if (nm_s3.done)
			packed_w = nm_s3.word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			al_s1 <= al;
			df_s2 <= df;
			nm_s3 <= nm;
			out_s4 <= packed_w;
		end
	end

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !out_ch.ready) |=> (v_s4 && $stable(out_s4)))
		else $error("result dropped under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s4 |-> in_ch.ready)
		else $error("input stalled with empty output");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s3) |=> v_s4)
		else $error("stage 3 item lost");
`endif
endmodule

// ----- src/fpsub_unpack.sv -----
// Unpack stage: compare magnitudes, pick the larger, settle special cases, align.
// Depends on fpsub_pkg.
module fpsub_unpack (
	input  logic [fpsub_pkg::WordW-1:0] a,
	input  logic [fpsub_pkg::WordW-1:0] b,
	input  logic [fpsub_pkg::WordW-1:0] default_nan,
	output fpsub_pkg::align_t           res
);
	localparam int unsigned FW = fpsub_pkg::FracW;
	localparam int unsigned EW = fpsub_pkg::ExpW;
	localparam int unsigned MW = fpsub_pkg::ManW;

	logic [EW-1:0] ea, eb, e1, e2, gap;
	logic [FW-1:0] fa, fb, f1, f2;
	logic          swap;
	logic [MW-1:0] m2full;

	always_comb begin
		ea = a[62:52];
		eb = b[62:52];
		fa = a[FW-1:0];
		fb = b[FW-1:0];
		swap = (ea < eb) || (ea == eb && fa < fb);
		res = '0;
		f1 = swap ? fb : fa;
		e1 = swap ? eb : ea;
		f2 = swap ? fa : fb;
		e2 = swap ? ea : eb;
		res.sign = a[63] ^ swap;
		res.e1 = e1;
		gap = e1 - e2;
		m2full = '0;
		if (swap && eb == fpsub_pkg::ExpMax) begin
			res.done = 1'b1;
			res.word = (fb != '0) ? b : {~b[63], b[62:0]};
		end else if (!swap && ea == fpsub_pkg::ExpMax) begin
			res.done = 1'b1;
			res.word = (fa == '0 && eb == fpsub_pkg::ExpMax) ? default_nan : a;
		end else if (e1 == '0) begin
			// Both denormal: subtract fractions directly.
			res.done = 1'b1;
			res.word = (f1 == f2) ? '0 : {res.sign, {EW{1'b0}}, f1 - f2};
		end else begin
			if (e2 == '0)
				gap = gap - EW'(1);
			res.m1 = {1'b0, 1'b1, f1, {fpsub_pkg::GuardW{1'b0}}};
			m2full = {1'b0, (e2 != '0), f2, {fpsub_pkg::GuardW{1'b0}}};
			if (gap <= fpsub_pkg::DropLimit)
				res.m2 = m2full >> gap;
		end
	end
endmodule

// ----- src/fpsub_norm.sv -----
// Normalize stage: leading-zero count and left shift, floored at exponent one.
// Depends on fpsub_pkg.
module fpsub_norm (
	input  fpsub_pkg::diff_t d,
	output fpsub_pkg::norm_t n
);
	localparam int unsigned MW = fpsub_pkg::ManW;
	localparam int unsigned EW = fpsub_pkg::ExpW;

	logic [fpsub_pkg::ShW-1:0] lz;
	logic [EW-1:0]             sh;

	always_comb begin
		// Count leading zeros from the hidden position (bit MW-2) downward.
		lz = '0;
		for (int i = 0; i <= int'(MW) - 2; i++) begin
			if (d.diff[i])
				lz = fpsub_pkg::ShW'(int'(MW) - 2 - i);
		end
		sh = EW'(lz);
		if (d.e1 <= sh)
			sh = d.e1 - EW'(1);
		n.done = d.done;
		n.word = d.word;
		n.sign = d.sign;
		n.e1 = d.e1 - sh;
		n.man = d.diff << sh;
	end
endmodule

// ----- tb/sv/fp64_same_sign_subtract_test.sv -----
// Self-checking test of the binary64 same-sign subtract unit.
// Depends on fpsub_pkg, fpsub_if and fp64_same_sign_subtract from the RTL.
// Drives subtract requests on in_ch, predicts each difference and checks out_ch in order.

// Holds the expected differences and the current default NaN.
// Computes each difference on its own, straight from the binary64 encoding.
class subtract_scoreboard;
	logic [63:0] default_nan;
	logic [63:0] expected_q[$];
	int          errors;
	int          checked;

	function new();
		default_nan = fpsub_pkg::DefaultNanReset;
		errors      = 0;
		checked     = 0;
	endfunction

	// Work out a minus b. The larger magnitude sets the sign. Same-sign operands are assumed.
	function logic [63:0] difference(logic [63:0] a, logic [63:0] b);
		logic [10:0] ea, eb;
		logic [51:0] fa, fb;
		logic [63:0] f1, f2, mag, expf;
		logic        sign, swap;
		int          e1, e2, gap;
		ea = a[62:52];
		eb = b[62:52];
		fa = a[51:0];
		fb = b[51:0];
		swap = (ea < eb) || (ea == eb && fa < fb);
		if (swap) begin
			// b is larger: a NaN passes as is, an infinity comes back negated
			if (eb == fpsub_pkg::ExpMax)
				return (fb != 0) ? b : {~b[63], b[62:0]};
			sign = ~a[63];
			f1 = {12'd0, fb};
			e1 = eb;
			f2 = {12'd0, fa};
			e2 = ea;
		end else begin
			if (ea == fpsub_pkg::ExpMax) begin
				if (fa != 0)
					return a;
				if (eb == fpsub_pkg::ExpMax)
					return default_nan;
				return a;
			end
			sign = a[63];
			f1 = {12'd0, fa};
			e1 = ea;
			f2 = {12'd0, fb};
			e2 = eb;
		end
		gap = e1 - e2;
		// both denormal: subtract the fractions directly
		if (e1 == 0) begin
			mag = (f1 - f2) & 64'h000F_FFFF_FFFF_FFFF;
			if (mag == 0)
				return 64'd0;
			return {sign, mag[62:0]};
		end
		f1[52] = 1'b1;
		if (e2 == 0)
			gap = gap - 1;
		else
			f2[52] = 1'b1;
		f1 = f1 << fpsub_pkg::GuardW;
		f2 = f2 << fpsub_pkg::GuardW;
		// drop the smaller operand when it lies too far below
		if (gap <= 53)
			f1 = f1 - (f2 >> gap);
		if (f1 == 0)
			return 64'd0;
		// normalize, stopping at exponent field 1
		while (e1 > 1 && !f1[58]) begin
			e1 = e1 - 1;
			f1 = f1 << 1;
		end
		// round half-up with no sticky, renormalize on carry-out
		f1 = f1 + 64'h20;
		if (f1[59]) begin
			e1 = e1 + 1;
			f1 = f1 >> 1;
		end
		expf = f1[58] ? 64'(e1) : 64'd0;
		return {sign, expf[10:0], f1[57:6]};
	endfunction

	function void note_request(logic [63:0] a, logic [63:0] b);
		expected_q.push_back(difference(a, b));
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	task report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("MISMATCH %s: result_bits %h, expected %h", what, got, want);
	endtask

	task check_result(logic [63:0] got);
		logic [63:0] want;
		checked++;
		if (expected_q.size() == 0) begin
			report("result with no request outstanding", got, 64'd0);
		end else begin
			want = expected_q.pop_front();
			if (got !== want)
				report("result_bits", got, want);
		end
	endtask
endclass

module fp64_same_sign_subtract_test;

	localparam int CycleLimit = 400000;
	localparam int RandomPerPhase = 310;
	// enough to flush the four pipeline stages and then some
	localparam int DrainCycles = 12;

	typedef enum int {
		OP_NORMAL, OP_DENORMAL, OP_ZERO, OP_INF, OP_NAN
	} operand_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [63:0] cfg_data = '0;

	// stimulus controls: quiet turns off random idling, hold_cycles holds the receiver
	logic quiet = 1'b0;
	int   hold_cycles = 0;
	int   cycle_count = 0;
	int   requests_sent = 0;
	int   special_sent = 0;

	subtract_scoreboard sb = new();

	fpsub_if req_if (.clk(clk));
	fpsub_if res_if (.clk(clk));

	fp64_same_sign_subtract u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.in_ch   (req_if.sink),
		.out_ch  (res_if.source)
	);

	always #2 clk = ~clk;

	initial begin
		req_if.valid       = 1'b0;
		req_if.a_bits      = '0;
		req_if.b_bits      = '0;
		req_if.result_bits = '0;
		res_if.ready       = 1'b0;
	end

	// Receiver: stall at random, or hold off for a counted stretch when asked.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			res_if.ready <= 1'b0;
		end else if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= quiet || ($urandom_range(99) >= 13);
		end
	end

	// Check every result taken at a rising edge.
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_result(res_if.result_bits);
	end

	// Watchdog: end the run if it stops making progress.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Timeout after %0d cycles, %0d results still outstanding",
				cycle_count, sb.pending());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offer one request; hold it until the block takes it. Valid stays high
	// into the next request unless a random idle cycle drops it first.
	task send_request(logic [63:0] a, logic [63:0] b);
		@(negedge clk);
		if (!quiet && $urandom_range(99) < 13) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid  <= 1'b1;
		req_if.a_bits <= a;
		req_if.b_bits <= b;
		do
			@(posedge clk);
		while (!req_if.ready);
		sb.note_request(a, b);
		requests_sent++;
		if (a[62:52] == fpsub_pkg::ExpMax || b[62:52] == fpsub_pkg::ExpMax)
			special_sent++;
	endtask

	// Drop valid and wait until every outstanding result is back, plus margin.
	task drain();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Write default_nan; only called with the pipeline empty.
	task write_default_nan(logic [63:0] value);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.default_nan = value;
	endtask

	function logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function logic [63:0] make_operand(logic sign, operand_kind_t kind, int expo);
		logic [63:0] v;
		v = rand64();
		v[63] = sign;
		case (kind)
			OP_NORMAL: begin
				v[62:52] = 11'(expo);
			end
			OP_DENORMAL: begin
				v[62:52] = '0;
			end
			OP_ZERO: begin
				v[62:0] = '0;
			end
			OP_INF: begin
				v[62:52] = fpsub_pkg::ExpMax;
				v[51:0]  = '0;
			end
			default: begin
				v[62:52] = fpsub_pkg::ExpMax;
				if (v[51:0] == 0)
					v[0] = 1'b1;
			end
		endcase
		return v;
	endfunction

	function operand_kind_t pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return OP_NORMAL;
		if (r < 89)
			return OP_DENORMAL;
		if (r < 93)
			return OP_ZERO;
		if (r < 97)
			return OP_INF;
		return OP_NAN;
	endfunction

	// One random request: mostly same-sign operands with nearby exponents,
	// which is where alignment, cancellation and rounding all happen.
	task send_random();
		logic [63:0] a, b;
		logic        sign;
		int          ea, eb, r;
		sign = $urandom_range(1);
		r = $urandom_range(99);
		ea = (r < 10) ? $urandom_range(3, 1) :
			(r < 15) ? $urandom_range(2046, 2040) : $urandom_range(2046, 1);
		r = $urandom_range(99);
		if (r < 70)
			eb = ea - 3 + $urandom_range(6);
		else if (r < 85)
			eb = ea - $urandom_range(60, 50);
		else
			eb = $urandom_range(2046, 1);
		if (eb < 1)
			eb = 1;
		if (eb > 2046)
			eb = 2046;
		a = make_operand(sign, pick_kind(), ea);
		b = make_operand(sign, pick_kind(), eb);
		r = $urandom_range(99);
		// near-equal fractions force deep cancellation or an exact zero
		if (r < 8)
			b[62:0] = a[62:0];
		else if (r < 18)
			b[51:0] = {a[51:8], 8'($urandom)};
		// a few mixed-sign requests: the block ignores the sign of b unless b is an infinity or NaN
		if ($urandom_range(99) < 8)
			b[63] = ~b[63];
		send_request(a, b);
	endtask

	task send_directed();
		send_request(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);
		send_request(64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF);
		send_request(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
		send_request(64'h3FF0_0000_0000_0000, 64'h3FE0_0000_0000_0000);
		send_request(64'h3FE0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
		send_request(64'h7FF0_0000_0000_0000, 64'h4000_0000_0000_0000);
		send_request(64'h4000_0000_0000_0000, 64'h7FF0_0000_0000_0000);
		send_request(64'hFFF0_0000_0000_0000, 64'hC000_0000_0000_0000);
		send_request(64'h7FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000);
		send_request(64'h7FF8_0000_0000_0001, 64'h3FF0_0000_0000_0000);
		send_request(64'h3FF0_0000_0000_0000, 64'h7FF0_0000_0000_0001);
		send_request(64'h7FF0_0000_0000_0002, 64'h7FFF_FFFF_FFFF_FFFF);
		send_request(64'h000F_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);
		send_request(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0000);
		send_request(64'h0010_0000_0000_0000, 64'h000F_FFFF_FFFF_FFFF);
		send_request(64'h0010_0000_0000_0001, 64'h0010_0000_0000_0000);
		send_request(64'h3FF0_0000_0000_0000, 64'h3CA0_0000_0000_0000);
		send_request(64'h3FF0_0000_0000_0000, 64'h3C90_0000_0000_0000);
		send_request(64'h3FFF_FFFF_FFFF_FFFF, 64'h3C80_0000_0000_0000);
		send_request(64'h3FF0_0000_0000_0000, 64'hBFE0_0000_0000_0000);
		send_request(64'hBFF8_0000_0000_0000, 64'hBFF0_0000_0000_0000);
		send_request(64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);
		send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000);
	endtask

	initial begin
		int i;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Phase 1: default NaN left at its reset value, directed cases first.
		send_directed();
		for (i = 0; i < RandomPerPhase; i++)
			send_random();
		drain();

		// Phase 2: default NaN all zeros, with a long run of no idling.
		write_default_nan(64'h0000_0000_0000_0000);
		send_request(64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000);
		for (i = 0; i < RandomPerPhase; i++) begin
			quiet = (i >= 50 && i < 250);
			send_random();
		end
		quiet = 1'b0;
		drain();

		// Phase 3: all ones; hold the receiver off while requests keep coming.
		write_default_nan(64'hFFFF_FFFF_FFFF_FFFF);
		send_request(64'hFFF0_0000_0000_0000, 64'hFFF0_0000_0000_0000);
		for (i = 0; i < RandomPerPhase; i++) begin
			if (i == 40)
				hold_cycles = 300;
			send_random();
		end
		drain();

		// Phase 4: random pattern; pause the sender once until all results return.
		write_default_nan(rand64());
		send_request(64'h7FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000);
		for (i = 0; i < RandomPerPhase; i++) begin
			if (i == RandomPerPhase / 2) begin
				@(negedge clk);
				req_if.valid <= 1'b0;
				while (sb.pending() != 0)
					@(posedge clk);
			end
			send_random();
		end
		drain();

		$display("Covered %0d subtract requests (%0d with an infinity or NaN) over four",
			requests_sent, special_sent);
		$display("default NaN settings; %0d results checked, %0d mismatches",
			sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
